/* rtl/ppru_pkg.sv */
// ----------------------------------------------------------------------------
// ppru_pkg
// shared types and constants for the partial permutation rank/unrank unit
// ----------------------------------------------------------------------------
package ppru_pkg;
    localparam int BOARD_CELLS_DEF = 16;
    localparam int MAX_PATTERN_DEF = 8;
    localparam int SCAN_CELLS      = 16;
    localparam int CELL_W          = 5;
    localparam int HALF_W          = 40;
    localparam int IDX_W           = 29;
    localparam int POS_W           = 4;
    localparam int DIG_W           = 5;
    localparam logic [4:0] BLANK_CODE = 5'd31;
    localparam logic [31:0] TILES_RESET = 32'h7654_3210;
    localparam logic [3:0]  LEN_RESET   = 4'd8;

    typedef enum logic [0:0] {
        OP_RANK   = 1'b0,
        OP_UNRANK = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        REG_TILES  = 1'b0,
        REG_LENGTH = 1'b1
    } t_reg;

    // per-item context passed cell to cell
    typedef struct packed {
        logic        vld;
        t_op         op;
        logic [2:0]  k_m1;
        logic [31:0] tiles;
    } t_ctl;
endpackage

/* rtl/partial_permutation_rank_unrank_unit.sv */
// ----------------------------------------------------------------------------
// partial_permutation_rank_unrank_unit
// lexicographic rank/unrank of pattern tile positions on a 16-cell board
// ----------------------------------------------------------------------------
// channel | signals                        | direction
// command | start busy i_operation ...     | in
// result  | o_done o_index_out o_board_*   | out, one-cycle strobe
// config  | i_cfg_valid o_cfg_ready idx dat| in
// one command per cycle; each result passes every cell and then the output register
// pipeline: 16 scan cells, 8 rank lowering cells, then the output register
// unrank digits are taken in the first cells and ride the rest of the chain
// synchronous active-low reset clears valid bits and the configuration registers
// busy is always low; results cannot be held off, nothing ever stalls
module partial_permutation_rank_unrank_unit
    import ppru_pkg::*;
#(
    parameter int BOARD_CELLS = BOARD_CELLS_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_operation,
    input  logic [HALF_W-1:0] i_board_in_low,
    input  logic [HALF_W-1:0] i_board_in_high,
    input  logic [IDX_W-1:0]  i_index_in,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_index_out,
    output logic [HALF_W-1:0] o_board_out_low,
    output logic [HALF_W-1:0] o_board_out_high,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    localparam int NCELL = SCAN_CELLS + MAX_PATTERN;

    logic [31:0] r_tiles;
    logic [3:0]  r_len;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles <= TILES_RESET;
            r_len   <= LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_TILES:  r_tiles <= i_cfg_data;
                REG_LENGTH: r_len   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // clamp of the slot count
    logic [3:0] k;
    always_comb begin
        k = (r_len == 4'd0) ? 4'd1 : r_len;
        if (int'(k) > MAX_PATTERN) k = 4'(MAX_PATTERN);
        if (int'(k) > BOARD_CELLS) k = 4'(BOARD_CELLS);
    end

    t_ctl                         c_ctl   [NCELL+1];
    logic [2*HALF_W-1:0]          c_board [NCELL+1];
    logic [IDX_W-1:0]             c_rem   [NCELL+1];
    logic [MAX_PATTERN*DIG_W-1:0] c_dig   [NCELL+1];

    assign c_ctl[0].vld   = start;
    assign c_ctl[0].op    = t_op'(i_operation);
    assign c_ctl[0].k_m1  = 3'(k - 4'd1);
    assign c_ctl[0].tiles = r_tiles;
    assign c_board[0]     = {i_board_in_high, i_board_in_low};
    assign c_rem[0]       = i_index_in;
    assign c_dig[0]       = '0;

    // cell chain
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        ppru_cell #(
            .BOARD_CELLS(BOARD_CELLS), .MAX_PATTERN(MAX_PATTERN), .STEP(g)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_ctl(c_ctl[g]), .i_board(c_board[g]), .i_rem(c_rem[g]), .i_dig(c_dig[g]),
            .o_ctl(c_ctl[g+1]), .o_board(c_board[g+1]), .o_rem(c_rem[g+1]),
            .o_dig(c_dig[g+1])
        );
    end

    ppru_finish #(.MAX_PATTERN(MAX_PATTERN)) u_fin (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ctl(c_ctl[NCELL]), .i_dig(c_dig[NCELL]), .i_rem(c_rem[NCELL]),
        .o_done(o_done), .o_index(o_index_out),
        .o_low(o_board_out_low), .o_high(o_board_out_high)
    );

    // a valid leaving the last cell is registered into a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ctl[NCELL].vld |=> o_done) else $error("result lost");
    a_zero_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_index_out != '0) |-> (o_board_out_low == '0))
        else $error("rank result carries board");
    a_zero_unrank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_board_out_low != '0) |-> (o_index_out == '0))
        else $error("unrank result carries index");
endmodule

/* rtl/ppru_cell.sv */
// ----------------------------------------------------------------------------
// ppru_cell
// one step of the chain: a board cell scan or a digit lowering for rank,
// one digit for unrank
// ----------------------------------------------------------------------------
module ppru_cell
    import ppru_pkg::*;
#(
    parameter int BOARD_CELLS = BOARD_CELLS_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int STEP        = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ctl                        i_ctl,
    input  logic [2*HALF_W-1:0]         i_board,
    input  logic [IDX_W-1:0]            i_rem,
    input  logic [MAX_PATTERN*DIG_W-1:0] i_dig,
    output t_ctl                        o_ctl,
    output logic [2*HALF_W-1:0]         o_board,
    output logic [IDX_W-1:0]            o_rem,
    output logic [MAX_PATTERN*DIG_W-1:0] o_dig
);
    // board cell scanned by this step
    localparam int VPOS    = (STEP < SCAN_CELLS) ? STEP : 0;
    // rank lowering slot of this step
    localparam int LI      = STEP - SCAN_CELLS;
    localparam int LPOS    = (LI >= 0 && LI < MAX_PATTERN) ? LI : 0;
    localparam int HRADIX  = (LI >= 0) ? BOARD_CELLS - LI : 1;
    // unrank digit of this step, divided by reciprocal multiplication
    localparam int UI      = MAX_PATTERN - 1 - STEP;
    localparam int UPOS    = (UI >= 0) ? UI : 0;
    localparam int URADIX  = (UI >= 0) ? BOARD_CELLS - UI : 1;
    localparam int USHIFT  = IDX_W + $clog2(URADIX);
    localparam logic [63:0] URECIP =
        ((64'd1 << USHIFT) + 64'(URADIX) - 64'd1) / 64'(URADIX);

    t_ctl                         r_ctl;
    logic [2*HALF_W-1:0]          r_board;
    logic [IDX_W-1:0]             r_rem, n_rem;
    logic [MAX_PATTERN*DIG_W-1:0] r_dig, n_dig;

    // rank: scan of cell STEP or lowering step STEP-SCAN_CELLS; unrank: digit UI
    always_comb begin
        logic [CELL_W-1:0] v;
        logic [DIG_W-1:0]  d;
        logic [DIG_W-1:0]  dj;
        logic [DIG_W-1:0]  cur;
        logic [63:0]       prod;
        logic [IDX_W-1:0]  q;
        n_dig = i_dig;
        n_rem = i_rem;
        v = i_board[VPOS*CELL_W +: CELL_W];
        prod = 64'(i_rem) * URECIP;
        q = IDX_W'(prod >> USHIFT);
        d = DIG_W'(i_rem - q * IDX_W'(URADIX));
        cur = i_dig[LPOS*DIG_W +: DIG_W];
        dj = '0;
        if (i_ctl.op == OP_RANK) begin
            if (STEP < SCAN_CELLS) begin
                if (STEP < BOARD_CELLS) begin
                    for (int j = 0; j < MAX_PATTERN; j++) begin
                        if (v == {1'b0, i_ctl.tiles[(j%8)*4 +: 4]})
                            n_dig[j*DIG_W +: DIG_W] = DIG_W'(VPOS);
                    end
                end
            end else if (LI >= 0 && LI <= int'(i_ctl.k_m1)) begin
                // later positions above this one move down, then horner step
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    dj = i_dig[j*DIG_W +: DIG_W];
                    if (j > LI && j <= int'(i_ctl.k_m1) && dj > cur)
                        n_dig[j*DIG_W +: DIG_W] = dj - 1'b1;
                end
                n_rem = (LI == 0) ? IDX_W'(cur)
                                  : i_rem * IDX_W'(HRADIX) + IDX_W'(cur);
            end
        end else if (UI >= 0 && UI <= int'(i_ctl.k_m1)) begin
            n_rem = q;
            n_dig[UPOS*DIG_W +: DIG_W] = d;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                dj = i_dig[j*DIG_W +: DIG_W];
                if (j > UI && j <= int'(i_ctl.k_m1) && dj >= d)
                    n_dig[j*DIG_W +: DIG_W] = dj + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ctl.vld <= 1'b0;
        else          r_ctl.vld <= i_ctl.vld;
        r_ctl.op    <= i_ctl.op;
        r_ctl.k_m1  <= i_ctl.k_m1;
        r_ctl.tiles <= i_ctl.tiles;
        r_board <= i_board;
        r_rem   <= n_rem;
        r_dig   <= n_dig;
    end

    assign o_ctl   = r_ctl;
    assign o_board = r_board;
    assign o_rem   = r_rem;
    assign o_dig   = r_dig;
endmodule

/* rtl/ppru_finish.sv */
// ----------------------------------------------------------------------------
// ppru_finish
// unrank board build and output register
// ----------------------------------------------------------------------------
module ppru_finish
    import ppru_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctl                         i_ctl,
    input  logic [MAX_PATTERN*DIG_W-1:0] i_dig,
    input  logic [IDX_W-1:0]             i_rem,
    output logic                         o_done,
    output logic [IDX_W-1:0]             o_index,
    output logic [HALF_W-1:0]            o_low,
    output logic [HALF_W-1:0]            o_high
);
    logic                 r_done;
    logic [IDX_W-1:0]     r_index;
    logic [HALF_W-1:0]    r_lo, r_hi;

    // board from unrank digits, later slots win
    logic [2*HALF_W-1:0] n_board;
    always_comb begin
        for (int c = 0; c < 16; c++) n_board[c*CELL_W +: CELL_W] = BLANK_CODE;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i <= int'(i_ctl.k_m1))
                n_board[int'(i_dig[i*DIG_W +: 4])*CELL_W +: CELL_W] =
                    {1'b0, i_ctl.tiles[(i%8)*4 +: 4]};
        end
    end

    // output register, rank index comes finished from the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= i_ctl.vld;
        r_index <= (i_ctl.op == OP_RANK) ? i_rem : '0;
        r_lo    <= (i_ctl.op == OP_UNRANK) ? n_board[HALF_W-1:0] : '0;
        r_hi    <= (i_ctl.op == OP_UNRANK) ? n_board[2*HALF_W-1:HALF_W] : '0;
    end

    assign o_done  = r_done;
    assign o_index = r_index;
    assign o_low   = r_lo;
    assign o_high  = r_hi;
endmodule

/* verif/partial_permutation_rank_unrank_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// partial_permutation_rank_unrank_unit_tb
// checks board rank and index unrank over several pattern settings
// ----------------------------------------------------------------------------
// a local predictor computes each expected transaction from the current
// pattern registers; results are matched in order against a queue of
// expected values. directed table first, then bursts of random commands.
module partial_permutation_rank_unrank_unit_tb;
    import ppru_pkg::*;

    typedef struct {
        t_op                op;
        logic [HALF_W-1:0]  brd_lo;
        logic [HALF_W-1:0]  brd_hi;
        logic [IDX_W-1:0]   idx;
    } t_cmd;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [HALF_W-1:0]  brd_lo;
        logic [HALF_W-1:0]  brd_hi;
    } t_res;

    typedef struct {
        t_cmd cmd;
        logic known;
        t_res res;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_operation;
    logic [HALF_W-1:0] i_board_in_low;
    logic [HALF_W-1:0] i_board_in_high;
    logic [IDX_W-1:0]  i_index_in;
    logic              o_done;
    logic [IDX_W-1:0]  o_index_out;
    logic [HALF_W-1:0] o_board_out_low;
    logic [HALF_W-1:0] o_board_out_high;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [31:0]       i_cfg_data;

    // predictor copy of the pattern registers
    logic [31:0] pat_tiles;
    logic [3:0]  pat_len;

    t_res expected_q[$];
    int   mismatch_cnt;
    int   result_cnt;
    int   rank_cnt;
    int   unrank_cnt;
    int   item_cnt;

    partial_permutation_rank_unrank_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_board_in_low  (i_board_in_low),
        .i_board_in_high (i_board_in_high),
        .i_index_in      (i_index_in),
        .o_done          (o_done),
        .o_index_out     (o_index_out),
        .o_board_out_low (o_board_out_low),
        .o_board_out_high(o_board_out_high),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5ms;
        $display("[partial_permutation_rank_unrank_unit] ERROR");
        $finish;
    end

    function automatic int slots_in_use();
        int k;
        k = pat_len;
        if (k == 0) k = 1;
        if (k > MAX_PATTERN_DEF) k = MAX_PATTERN_DEF;
        if (k > BOARD_CELLS_DEF) k = BOARD_CELLS_DEF;
        return k;
    endfunction

    function automatic logic [3:0] tile_of_slot(int s);
        return pat_tiles[4*s +: 4];
    endfunction

    // lexicographic rank of the pattern tile positions
    function automatic logic [IDX_W-1:0] rank_board(logic [HALF_W-1:0] lo,
                                                    logic [HALF_W-1:0] hi);
        int          k;
        int          pos[MAX_PATTERN_DEF];
        logic [79:0] cells;
        logic [4:0]  code;
        longint      sum;
        longint      weight;
        k = slots_in_use();
        cells = {hi, lo};
        sum = 0;
        weight = 1;
        for (int i = 0; i < MAX_PATTERN_DEF; i++) pos[i] = 0;
        for (int c = 0; c < BOARD_CELLS_DEF; c++) begin
            code = cells[5*c +: 5];
            for (int j = 0; j < k; j++)
                if (code == {1'b0, tile_of_slot(j)}) pos[j] = c;
        end
        for (int i = 0; i < k; i++)
            for (int j = i + 1; j < k; j++)
                if (pos[j] > pos[i]) pos[j]--;
        for (int i = k - 1; i >= 0; i--) begin
            sum += longint'(pos[i]) * weight;
            weight *= (BOARD_CELLS_DEF - i);
        end
        return sum[IDX_W-1:0];
    endfunction

    // inverse mapping: index to a board holding only the pattern tiles
    function automatic logic [79:0] unrank_index(logic [IDX_W-1:0] idx);
        int          k;
        int          digit[MAX_PATTERN_DEF];
        longint      rem;
        int          radix;
        logic [79:0] cells;
        k = slots_in_use();
        rem = idx;
        for (int i = k - 1; i >= 0; i--) begin
            radix = BOARD_CELLS_DEF - i;
            digit[i] = int'(rem % radix);
            rem = rem / radix;
            for (int j = i + 1; j < k; j++)
                if (digit[j] >= digit[i]) digit[j]++;
        end
        for (int c = 0; c < 16; c++) cells[5*c +: 5] = BLANK_CODE;
        for (int i = 0; i < k; i++) cells[5*(digit[i] & 15) +: 5] = {1'b0, tile_of_slot(i)};
        return cells;
    endfunction

    function automatic t_res predict_result(t_cmd cmd);
        t_res        r;
        logic [79:0] cells;
        if (cmd.op == OP_RANK) begin
            r.idx = rank_board(cmd.brd_lo, cmd.brd_hi);
            r.brd_lo = '0;
            r.brd_hi = '0;
        end else begin
            cells = unrank_index(cmd.idx);
            r.idx = '0;
            r.brd_lo = cells[39:0];
            r.brd_hi = cells[79:40];
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            result_cnt++;
            if (expected_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result idx=%h lo=%h hi=%h", o_index_out,
                             o_board_out_low, o_board_out_high);
            end else begin
                want = expected_q.pop_front();
                if (o_index_out !== want.idx || o_board_out_low !== want.brd_lo ||
                    o_board_out_high !== want.brd_hi) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp idx=%h lo=%h hi=%h got idx=%h lo=%h hi=%h",
                                 want.idx, want.brd_lo, want.brd_hi, o_index_out,
                                 o_board_out_low, o_board_out_high);
                end
            end
        end
    end

    // register write on the config channel, only while idle
    task automatic write_reg(t_reg which, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (which == REG_TILES) pat_tiles = value;
        else pat_len = value[3:0];
    endtask

    // one command transaction; start stays high across back-to-back commands
    task automatic send_cmd(t_cmd cmd, logic known, t_res typed);
        t_res r;
        r = predict_result(cmd);
        if (known) r = typed;
        start           <= 1'b1;
        i_operation     <= cmd.op;
        i_board_in_low  <= cmd.brd_lo;
        i_board_in_high <= cmd.brd_hi;
        i_index_in      <= cmd.idx;
        do @(posedge i_clk); while (busy);
        expected_q.insert(expected_q.size(), r);
        item_cnt++;
        if (cmd.op == OP_RANK) rank_cnt++;
        else unrank_cnt++;
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (expected_q.size() != 0 && guard < 2000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (24) @(negedge i_clk);
    endtask

    // random board: mostly permutations of ids with blanks, some raw noise
    function automatic t_cmd random_cmd();
        t_cmd        cmd;
        logic [79:0] cells;
        int          perm[16];
        int          j;
        int          tmp;
        cmd.op = t_op'($urandom_range(0, 1));
        cmd.idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                               : IDX_W'($urandom_range(0, 518918399));
        if ($urandom_range(0, 4) == 0) begin
            cells = 80'({$urandom, $urandom, $urandom});
        end else begin
            for (int i = 0; i < 16; i++) perm[i] = i;
            for (int i = 15; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
            end
            for (int c = 0; c < 16; c++)
                cells[5*c +: 5] = ($urandom_range(0, 15) == 0) ? BLANK_CODE
                                                                : 5'(perm[c]);
        end
        cmd.brd_lo = cells[39:0];
        cmd.brd_hi = cells[79:40];
        return cmd;
    endfunction

    // directed table
    t_row dir_rows[$];

    task automatic add_row(t_op op, logic [79:0] cells, logic [IDX_W-1:0] idx,
                           logic known, logic [IDX_W-1:0] w_idx, logic [79:0] w_cells);
        t_row row;
        row.cmd.op = op;
        row.cmd.brd_lo = cells[39:0];
        row.cmd.brd_hi = cells[79:40];
        row.cmd.idx = idx;
        row.known = known;
        row.res.idx = w_idx;
        row.res.brd_lo = w_cells[39:0];
        row.res.brd_hi = w_cells[79:40];
        dir_rows.insert(dir_rows.size(), row);
    endtask

    initial begin
        logic [79:0] ident;
        logic [79:0] rev;
        logic [79:0] blanks;
        logic [79:0] unrank0;
        int          burst;
        logic [31:0] tiles_set[4];
        logic [3:0]  len_set[6];
        start = 1'b0;
        i_operation = OP_RANK;
        i_board_in_low = '0;
        i_board_in_high = '0;
        i_index_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_TILES;
        i_cfg_data = '0;
        mismatch_cnt = 0;
        result_cnt = 0;
        rank_cnt = 0;
        unrank_cnt = 0;
        item_cnt = 0;
        pat_tiles = TILES_RESET;
        pat_len = LEN_RESET;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int c = 0; c < 16; c++) begin
            ident[5*c +: 5] = 5'(c);
            rev[5*c +: 5] = 5'(15 - c);
            blanks[5*c +: 5] = BLANK_CODE;
        end
        unrank0 = blanks;
        for (int c = 0; c < 8; c++) unrank0[5*c +: 5] = 5'(c);

        // reset pattern: identity board ranks 0, index 0 unranks to tiles in order
        add_row(OP_RANK, ident, '0, 1'b1, '0, '0);
        add_row(OP_UNRANK, '0, '0, 1'b1, '0, unrank0);
        add_row(OP_RANK, rev, '0, 1'b0, '0, '0);
        // absent tiles: all blank
        add_row(OP_RANK, blanks, '0, 1'b0, '0, '0);
        // all-ones and all-zero inputs, repeated tiles
        add_row(OP_RANK, {80{1'b1}}, '1, 1'b0, '0, '0);
        add_row(OP_RANK, '0, '0, 1'b0, '0, '0);
        add_row(OP_UNRANK, '0, 29'd518918399, 1'b0, '0, '0);
        add_row(OP_UNRANK, {80{1'b1}}, '1, 1'b0, '0, '0);
        add_row(OP_UNRANK, '0, 29'd518918400, 1'b0, '0, '0);
        add_row(OP_RANK, {ident[39:0], ident[39:0]}, '0, 1'b0, '0, '0);
        add_row(OP_RANK, 80'h5555_5555_5555_5555_5555, '0, 1'b0, '0, '0);
        add_row(OP_RANK, 80'hAAAA_AAAA_AAAA_AAAA_AAAA, 29'h0AAA_AAAA, 1'b0, '0, '0);
        add_row(OP_UNRANK, '0, 29'h1555_5555, 1'b0, '0, '0);
        add_row(OP_UNRANK, '0, 29'd1, 1'b0, '0, '0);

        foreach (dir_rows[r]) send_cmd(dir_rows[r].cmd, dir_rows[r].known, dir_rows[r].res);
        drain();

        tiles_set = '{32'h7654_3210, 32'hFEDC_BA98, 32'h0000_0000, 32'hFFFF_FFFF};
        len_set = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};

        // random phases across pattern settings
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_TILES, (ph < 4) ? tiles_set[ph] : $urandom);
            write_reg(REG_LENGTH, {28'b0, len_set[ph % 6]} |
                                  ((ph >= 6) ? 32'($urandom_range(0, 15)) : 32'd0));
            for (int n = 0; n < 117; ) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 117; b++, n++)
                    send_cmd(random_cmd(), 1'b0, '{default: '0});
                if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
            end
            drain();
        end

        $display("%0d commands sent (%0d rank, %0d unrank), %0d results checked",
                 item_cnt, rank_cnt, unrank_cnt, result_cnt);
        $display("covered 12 pattern settings incl. length 0, 1, 8, 15; %0d mismatches",
                 mismatch_cnt);
        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("[partial_permutation_rank_unrank_unit] OK");
        else
            $display("[partial_permutation_rank_unrank_unit] ERROR");
        $finish;
    end
endmodule
